// ----- sv/pcx_pkg.sv -----
package pcx_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned COL_W   = 19;
  localparam int unsigned LINE_W  = 17;
  localparam int unsigned WIDTH_W = 17;
  localparam int unsigned BPL_W   = 16;
  localparam int unsigned RUN_W   = 6;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned TDATA_OUT_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_LINE = 3'd4;

  localparam logic [PIX_W-1:0] RUN_MARK = 8'hC0;
  localparam logic [PIX_W-1:0] RUN_MASK = 8'h3F;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // position step computed for one pixel group
  typedef struct packed {
    logic [CNT_W-1:0]  vis;
    logic [COL_W-1:0]  col_next;
    logic [LINE_W-1:0] line_next;
    logic              eoi;
  } grp_step_t;

endpackage

// ----- sv/pcx_grp.sv -----
module pcx_grp (
  input  logic [1:0]                    pixel_depth,
  input  logic [pcx_pkg::WIDTH_W-1:0]   image_width,
  input  logic [pcx_pkg::LINE_W-1:0]    image_height,
  input  logic [pcx_pkg::BPL_W-1:0]     bytes_per_line,
  input  logic [pcx_pkg::COL_W-1:0]     col,
  input  logic [pcx_pkg::LINE_W-1:0]    line,
  output pcx_pkg::grp_step_t            step
);
  import pcx_pkg::*;

  logic [CNT_W-1:0]   ppb;
  logic [COL_W-1:0]   len_bytes;
  logic [COL_W-1:0]   line_len;
  logic [COL_W:0]     next_col;
  logic [WIDTH_W-1:0] diff;
  logic [LINE_W:0]    line_inc;

  always_comb begin
    ppb       = 4'd8 >> pixel_depth;
    len_bytes = {3'b000, bytes_per_line} << (2'd3 - pixel_depth);
    line_len  = ({2'b00, image_width} > len_bytes) ? {2'b00, image_width} : len_bytes;
    next_col  = {1'b0, col} + {{(COL_W-3){1'b0}}, ppb};
    diff      = image_width - col[WIDTH_W-1:0];
    line_inc  = {1'b0, line} + {{LINE_W{1'b0}}, 1'b1};

    step.vis = '0;
    if (col < {2'b00, image_width}) begin
      step.vis = (diff > {{(WIDTH_W-CNT_W){1'b0}}, ppb}) ? ppb : diff[CNT_W-1:0];
    end

    step.eoi       = 1'b0;
    step.col_next  = next_col[COL_W-1:0];
    step.line_next = line;
    if (next_col >= {1'b0, line_len}) begin
      step.col_next = '0;
      if (line_inc >= {1'b0, image_height}) begin
        step.line_next = '0;
        step.eoi       = 1'b1;
      end else begin
        step.line_next = line_inc[LINE_W-1:0];
      end
    end
  end

endmodule

// ----- sv/pcx_rle_pixel_decoder_core.sv -----
// Channel  Dir  Payload (low bit up)                              Marks
// s_*      in   tdata: data_byte[7:0]                             -
// m_*      out  tdata: row, column, pixel_byte, pixel_count, 0s   tlast=last_of_run,
//                                                                 tuser=end_of_image
// cfg_*    in   index 0..4, data up to 17 bits                    -
//
// A request is accepted only while the sequencer is idle. A literal byte
// loads its one result once the output is free, and no new byte is taken until
// then. A run byte of count n loads n results, one per cycle while m_tready
// does not stall, and holds s_tready low until its last result is loaded.
// A run header or the value byte of an empty run produces no result and
// leaves the sequencer idle. Synchronous reset restores the register defaults and
// row 0, column 0.
module pcx_rle_pixel_decoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte[7:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [pcx_pkg::TDATA_OUT_W-1:0]  m_tdata,   // row[15:0], column[31:16],
                                                      // pixel_byte[39:32],
                                                      // pixel_count[43:40], zero pad
  output logic                             m_tlast,
  output logic                             m_tuser,   // end_of_image[0]
  input  logic                             cfg_wr_en,
  input  logic [pcx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcx_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcx_pkg::*;

  logic [1:0]          pixel_depth;
  logic                rle_enable;
  logic [WIDTH_W-1:0]  image_width;
  logic [LINE_W-1:0]   image_height;
  logic [BPL_W-1:0]    bytes_per_line;

  state_t              state, state_next;
  logic [COL_W-1:0]    pixel_column;
  logic [LINE_W-1:0]   line_index;
  logic                count_pending;
  logic [RUN_W-1:0]    pending_count;
  logic [RUN_W-1:0]    run_left;
  logic [PIX_W-1:0]    run_byte;

  logic                in_take;
  logic                is_header;
  logic                out_free;
  logic                load;
  logic                last;
  logic [RUN_W-1:0]    run_len;
  grp_step_t           step;

  logic [ROW_W-1:0]    out_row;
  logic [ROW_W-1:0]    out_col;
  logic [PIX_W-1:0]    out_byte;
  logic [CNT_W-1:0]    out_cnt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_depth    <= 2'd3;
      rle_enable     <= 1'b1;
      image_width    <= 17'd640;
      image_height   <= 17'd480;
      bytes_per_line <= 16'd640;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PIXEL_DEPTH:    pixel_depth    <= cfg_data[1:0];
        REG_RLE_ENABLE:     rle_enable     <= cfg_data[0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[LINE_W-1:0];
        REG_BYTES_PER_LINE: bytes_per_line <= cfg_data[BPL_W-1:0];
        default: ;
      endcase
    end
  end

  pcx_grp u_grp (
    .pixel_depth    (pixel_depth),
    .image_width    (image_width),
    .image_height   (image_height),
    .bytes_per_line (bytes_per_line),
    .col            (pixel_column),
    .line           (line_index),
    .step           (step)
  );

  assign in_take   = s_tvalid && s_tready;
  assign is_header = rle_enable && !count_pending && ((s_tdata & RUN_MARK) == RUN_MARK);
  assign out_free  = !m_tvalid || m_tready;
  assign load      = (state == ST_RUN) && out_free;
  assign last      = (run_left == {{(RUN_W-1){1'b0}}, 1'b1});

  always_comb begin
    if (rle_enable && count_pending) begin
      run_len = pending_count;
    end else begin
      run_len = {{(RUN_W-1){1'b0}}, 1'b1};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && !is_header && (run_len != '0)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load && last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_RUN:  s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_pending <= 1'b0;
      pending_count <= '0;
      pixel_column  <= '0;
      line_index    <= '0;
      run_left      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (in_take) begin
        if (is_header) begin
          count_pending <= 1'b1;
          pending_count <= s_tdata[RUN_W-1:0] & RUN_MASK[RUN_W-1:0];
        end else begin
          count_pending <= 1'b0;
          pending_count <= '0;
          run_left      <= run_len;
        end
      end
      if (load) begin
        // advance the position and count down the run
        pixel_column <= step.col_next;
        line_index   <= step.line_next;
        run_left     <= run_left - {{(RUN_W-1){1'b0}}, 1'b1};
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      run_byte <= s_tdata;
    end
    if (load) begin
      out_row  <= line_index[ROW_W-1:0];
      out_col  <= pixel_column[ROW_W-1:0];
      out_byte <= run_byte;
      out_cnt  <= step.vis;
      m_tlast  <= last;
      m_tuser  <= step.eoi;
    end
  end

  assign m_tdata = {4'b0000, out_cnt, out_byte, out_col, out_row};

  // a run in progress always has groups left
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (run_left != '0))
    else $error("run active with no groups left");

  // the final group of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && last) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("run did not close after its last group");

  // end of image wraps the position to the origin
  a_eoi_wrap: assert property (@(posedge clk) disable iff (rst)
    (load && step.eoi) |=> (line_index == '0) && (pixel_column == '0))
    else $error("position not reset at end of image");

  // visible pixel count never exceeds one byte
  a_vis_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[43:40] <= 4'd8))
    else $error("pixel count out of range");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import pcx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 16;
  localparam int unsigned HOLD_CYCLES  = 200;

  typedef struct {
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  pixel_byte;
    logic [3:0]  pixel_count;
    logic        end_of_image;
    logic        last_of_run;
  } pixel_group_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] index;
    int unsigned          value;
    logic [7:0]           data;
    bit                   typed;
    pixel_group_t         group;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // decoder shadow: configuration and position
  int unsigned depth_code, rle_on, img_width, img_height, line_bytes;
  int unsigned cur_column, cur_line, run_len;
  bit          run_pending;
  pixel_group_t groups_due[$];

  bit           use_typed;
  pixel_group_t typed_group;
  int unsigned  tx_idle_pct, rx_stall_pct;
  int unsigned  hold_len, hold_left;
  bit           hold_go;
  int unsigned  err_count, bytes_accepted, groups_checked, settings_count;
  int unsigned  cycle_count;
  stim_row_t    directed_rows[$];

  pcx_rle_pixel_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    case (idx)
      REG_PIXEL_DEPTH:    depth_code = val & 32'h3;
      REG_RLE_ENABLE:     rle_on     = val & 32'h1;
      REG_IMAGE_WIDTH:    img_width  = val & 32'h1FFFF;
      REG_IMAGE_HEIGHT:   img_height = val & 32'h1FFFF;
      REG_BYTES_PER_LINE: line_bytes = val & 32'hFFFF;
      default: ;
    endcase
  endfunction

  function automatic void emit_pixel_group(logic [7:0] value, bit last);
    int unsigned  ppb, col, vis, len, nxt;
    pixel_group_t g;
    ppb = 8 >> depth_code;
    col = cur_column;
    vis = 0;
    if (col < img_width) begin
      vis = img_width - col;
      if (vis > ppb) vis = ppb;
    end
    len = line_bytes * ppb;
    if (img_width > len) len = img_width;
    nxt = col + ppb;
    g.row          = cur_line[15:0];
    g.column       = col[15:0];
    g.pixel_byte   = value;
    g.pixel_count  = vis[3:0];
    g.end_of_image = 1'b0;
    g.last_of_run  = last;
    // wrap to the next line once the group reaches the line end
    if (nxt >= len) begin
      cur_column = 0;
      if (cur_line + 1 >= img_height) begin
        cur_line = 0;
        g.end_of_image = 1'b1;
      end else begin
        cur_line = (cur_line + 1) & 32'h1FFFF;
      end
    end else begin
      cur_column = nxt & 32'h7FFFF;
    end
    groups_due = {groups_due, g};
  endfunction

  function automatic void decode_pcx_byte(logic [7:0] b);
    int unsigned n;
    int unsigned k;
    if (rle_on == 0) begin
      run_pending = 0;
      run_len = 0;
      n = 1;
    end else if (run_pending) begin
      n = run_len;
      run_pending = 0;
      run_len = 0;
    end else if ((b & RUN_MARK) == RUN_MARK) begin
      run_len = b & RUN_MASK;
      run_pending = 1;
      n = 0;
    end else begin
      n = 1;
    end
    for (k = 0; k < n; k++) emit_pixel_group(b, k == n - 1);
  endfunction

  function automatic void report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b);
    stim_row_t r;
    r = '{default: '0};
    r.data = b;
    return r;
  endfunction

  // literal at row 0 with one visible pixel, last of its request
  function automatic stim_row_t lit_row(logic [7:0] b, logic [15:0] col);
    stim_row_t r;
    r = byte_row(b);
    r.typed = 1;
    r.group = '{row: 16'd0, column: col, pixel_byte: b, pixel_count: 4'd1,
                end_of_image: 1'b0, last_of_run: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // predict on every accepted request, then check every accepted result
  always @(posedge clk) begin
    int unsigned  sz;
    pixel_group_t want;
    if (!rst && s_tvalid && s_tready) begin
      bytes_accepted++;
      sz = groups_due.size();
      decode_pcx_byte(s_tdata);
      if (use_typed) begin
        while (groups_due.size() > sz) void'(groups_due.pop_back());
        groups_due = {groups_due, typed_group};
        use_typed = 0;
      end
    end
    if (!rst && m_tvalid && m_tready) begin
      groups_checked++;
      if (groups_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got row %0d column %0d byte %0h",
                 $time, m_tdata[15:0], m_tdata[31:16], m_tdata[39:32]);
        err_count++;
      end else begin
        want = groups_due.pop_front();
        report_field("row", want.row, m_tdata[15:0]);
        report_field("column", want.column, m_tdata[31:16]);
        report_field("pixel_byte", want.pixel_byte, m_tdata[39:32]);
        report_field("pixel_count", want.pixel_count, m_tdata[43:40]);
        report_field("end_of_image", want.end_of_image, m_tuser);
        report_field("last_of_run", want.last_of_run, m_tlast);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = hold_len;
      hold_go = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               groups_due.size());
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, bit typed, pixel_group_t grp);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    use_typed = typed;
    typed_group = grp;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid, drain every due result, then let a swallowed run settle
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (groups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    apply_register(idx, val);
    settings_count++;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  initial begin
    pixel_group_t no_group;
    int unsigned  items, cnt, sel;
    logic [7:0]   b;
    clk = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    m_tready = 0;
    cfg_wr_en = 0;
    cfg_index = '0;
    cfg_data = '0;
    no_group = '{default: '0};
    depth_code = 3;
    rle_on = 1;
    img_width = 640;
    img_height = 480;
    line_bytes = 640;
    cur_column = 0;
    cur_line = 0;
    run_pending = 0;
    run_len = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;

    // reset defaults: 8 bpp, coded, 640 x 480
    add_row(lit_row(8'h00, 16'd0));
    add_row(lit_row(8'hBF, 16'd1));
    add_row(lit_row(8'h7F, 16'd2));
    add_row(byte_row(8'hC3));
    add_row(byte_row(8'hFF));
    // empty run swallows its value byte
    add_row(byte_row(8'hC0));
    add_row(byte_row(8'h55));
    // run value that looks like a header
    add_row(byte_row(8'hC1));
    add_row(byte_row(8'hC0));
    // 1 bpp, 10 wide, 2 lines, padded to 16 pixels
    add_row(cfg_row(REG_PIXEL_DEPTH, 0));
    add_row(cfg_row(REG_IMAGE_WIDTH, 10));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 2));
    add_row(cfg_row(REG_BYTES_PER_LINE, 2));
    add_row(byte_row(8'hA5));
    add_row(byte_row(8'h5A));
    add_row(byte_row(8'hFF));
    add_row(byte_row(8'h01));
    add_row(byte_row(8'hC2));
    add_row(byte_row(8'h80));
    // zero height: every line ends the image
    add_row(cfg_row(REG_IMAGE_HEIGHT, 0));
    add_row(byte_row(8'h12));
    // narrow image: second byte is pure padding
    add_row(cfg_row(REG_IMAGE_WIDTH, 3));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 1));
    add_row(byte_row(8'h81));
    add_row(byte_row(8'h42));
    add_row(byte_row(8'h24));
    // raw mode at 4 bpp: header bytes are plain pixels
    add_row(cfg_row(REG_RLE_ENABLE, 0));
    add_row(cfg_row(REG_PIXEL_DEPTH, 2));
    add_row(byte_row(8'hC5));
    add_row(byte_row(8'hFF));
    add_row(byte_row(8'h3C));
    // largest sizes with the longest run
    add_row(cfg_row(REG_RLE_ENABLE, 1));
    add_row(cfg_row(REG_PIXEL_DEPTH, 1));
    add_row(cfg_row(REG_IMAGE_WIDTH, 65536));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 65536));
    add_row(cfg_row(REG_BYTES_PER_LINE, 65535));
    add_row(byte_row(8'hFF));
    add_row(byte_row(8'h96));
    // smallest image: one pixel
    add_row(cfg_row(REG_PIXEL_DEPTH, 3));
    add_row(cfg_row(REG_IMAGE_WIDTH, 1));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 1));
    add_row(cfg_row(REG_BYTES_PER_LINE, 1));
    add_row(byte_row(8'h7E));

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        cfg_write(directed_rows[i].index, directed_rows[i].value);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].group);
      end
    end
    wait_idle();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      cfg_write(REG_PIXEL_DEPTH, $urandom_range(3));
      cfg_write(REG_RLE_ENABLE, (phase == 3) ? 0 : 1);
      if (phase == 5) begin
        cfg_write(REG_IMAGE_WIDTH, 65536);
        cfg_write(REG_IMAGE_HEIGHT, 65536);
        cfg_write(REG_BYTES_PER_LINE, 65535);
      end else begin
        cfg_write(REG_IMAGE_WIDTH, $urandom_range(24, 1));
        cfg_write(REG_IMAGE_HEIGHT, $urandom_range(3, 1));
        cfg_write(REG_BYTES_PER_LINE, $urandom_range(4, 1));
      end
      // stall the output long enough to back up the input
      if (phase == 4) begin
        hold_len = HOLD_CYCLES;
        hold_go = 1;
      end
      items = 0;
      while (items < PHASE_ITEMS) begin
        if (phase == 2 && items >= PHASE_ITEMS / 2 && items < PHASE_ITEMS / 2 + 2)
          wait_idle();
        sel = $urandom_range(99);
        if (sel < 45) begin
          sel = $urandom_range(9);
          cnt = (sel == 0) ? 63 : (sel == 1) ? 0 : $urandom_range(8, 1);
          send_byte(RUN_MARK | cnt[7:0], 0, no_group);
          b = $urandom_range(255);
          send_byte(b, 0, no_group);
          items += 2;
        end else if (sel < 90) begin
          b = $urandom_range(191);
          send_byte(b, 0, no_group);
          items++;
        end else begin
          b = $urandom_range(255);
          send_byte(b, 0, no_group);
          items++;
        end
      end
      wait_idle();
    end

    $display("covered %0d input bytes and %0d pixel groups over %0d register writes,",
             bytes_accepted, groups_checked, settings_count);
    $display("all depths, coded and raw, padding, empty runs, image wrap, size extremes");
    if (err_count == 0 && groups_due.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", err_count, groups_due.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
